/* rtl/light_gate_speed_timer_defines.svh */
// Assertion macros shared by the light gate speed timer RTL.
`ifndef LIGHT_GATE_SPEED_TIMER_DEFINES_SVH
`define LIGHT_GATE_SPEED_TIMER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LGST_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("light gate speed timer: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LGST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("light gate speed timer: next-cycle check failed");

`endif

/* rtl/lgst_pkg.sv */
// Package with the types and constants of the light gate speed timer.
package lgst_pkg;

    // Width of the tick counter.
    localparam int COUNT_WIDTH = 16;
    // Width of the distance numerator, the speed and the elapsed count fields.
    localparam int NUM_W       = 16;
    localparam int SPEED_W     = 16;
    localparam int ELAPSED_W   = 16;
    // The divider retires one quotient bit per cycle.
    localparam int DIV_STEPS   = NUM_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    // Width wide enough to compare any count against the elapsed field maximum.
    localparam int WIDE_W      = 33;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = {COUNT_WIDTH{1'b1}};
    localparam logic [NUM_W-1:0]       NUM_RESET    = NUM_W'(45720);
    localparam logic [SPEED_W-1:0]     SPEED_MAX    = {SPEED_W{1'b1}};
    localparam logic [ELAPSED_W-1:0]   ELAPSED_MAX  = {ELAPSED_W{1'b1}};
    localparam logic [STEP_W-1:0]      STEP_LAST    = STEP_W'(DIV_STEPS - 1);

    // Input item kinds.
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_EVENT = 1'b1;
    // Gate level meaning the beam is interrupted.
    localparam logic LEVEL_BLOCKED = 1'b0;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DIVIDE
    } lgst_state_t;

    // Elapsed count as reported, saturated at the field maximum.
    function automatic logic [ELAPSED_W-1:0] sat_elapsed(input logic [COUNT_WIDTH-1:0] cnt);
        logic [WIDE_W-1:0] wide;
        wide = WIDE_W'(cnt);
        if (wide > WIDE_W'(ELAPSED_MAX))
            sat_elapsed = ELAPSED_MAX;
        else
            sat_elapsed = wide[ELAPSED_W-1:0];
    endfunction

endpackage

/* rtl/light_gate_speed_timer.sv */
// Light gate speed timer: arming, tick counting and bit-serial speed division.
// A stop event with a zero count shows its result in the cycle after it is taken;
// any other stop event shows its result once the divider has finished.
// Throughput: one item per cycle, except that the 16-step restoring divider holds
// off input while it runs, and input stalls while armed with an untaken result.
// Reset (rst_n low, asynchronous) disarms, clears the count and loads 45720.
`include "light_gate_speed_timer_defines.svh"

module light_gate_speed_timer
    import lgst_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input item channel.
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   action,
    input  logic                   gate_a_level,
    input  logic                   gate_b_level,
    // Result item channel.
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [ELAPSED_W-1:0]   elapsed_ticks,
    output logic [SPEED_W-1:0]     speed_mm_s,
    output logic                   zero_time_error,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [NUM_W-1:0]       distance_numerator
);

    // Control state.
    lgst_state_t              state_reg, state_next;
    logic                     armed_reg, armed_next;
    logic [COUNT_WIDTH-1:0]   tick_count_reg, tick_count_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     out_valid_reg, out_valid_next;
    logic [NUM_W-1:0]         numerator_reg, numerator_next;

    // Divider datapath and result registers.
    logic [COUNT_WIDTH:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]         quot_reg, quot_next;
    logic [ELAPSED_W-1:0]     elapsed_reg, elapsed_next;
    logic [SPEED_W-1:0]       speed_reg, speed_next;
    logic                     err_reg, err_next;

    logic                     in_accept;
    logic [COUNT_WIDTH:0]     rem_shift;
    logic [COUNT_WIDTH:0]     rem_diff;

    // Input is held off while the divider runs. It is also held off while a result
    // is still waiting and the timer is armed, since only an armed timer can fire;
    // this keeps the output register free whenever a new result may be produced.
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && armed_reg);
    assign in_accept = in_valid && !in_stall;

    // The register may be written whenever no division is under way.
    assign cfg_ready = (state_reg == ST_IDLE);

    assign out_valid       = out_valid_reg;
    assign elapsed_ticks   = elapsed_reg;
    assign speed_mm_s      = speed_reg;
    assign zero_time_error = err_reg;

    // One restoring step: bring down the next dividend bit and try the subtraction.
    // The divisor is the tick count itself, which cannot move during a division.
    assign rem_shift = {rem_reg[COUNT_WIDTH-1:0], quot_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, tick_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            armed_reg      <= 1'b0;
            tick_count_reg <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            numerator_reg  <= NUM_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            armed_reg      <= armed_next;
            tick_count_reg <= tick_count_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
            numerator_reg  <= numerator_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        elapsed_reg <= elapsed_next;
        speed_reg   <= speed_next;
        err_reg     <= err_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        armed_next      = armed_reg;
        tick_count_next = tick_count_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg;
        numerator_next  = numerator_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        elapsed_next    = elapsed_reg;
        speed_next      = speed_reg;
        err_next        = err_reg;

        if (cfg_valid && cfg_ready)
            numerator_next = distance_numerator;

        // A waiting result leaves once the far side stops stalling.
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (action == ACT_TICK)
                    begin
                        // Ticks count only while armed and stop at the top.
                        if (armed_reg && (tick_count_reg != COUNT_MAX))
                            tick_count_next = tick_count_reg + COUNT_WIDTH'(1);
                    end
                    else if (!armed_reg)
                    begin
                        // First gate blocked: restart the count and arm. The second
                        // gate is ignored here, so both blocked only arms.
                        if (gate_a_level == LEVEL_BLOCKED)
                        begin
                            tick_count_next = '0;
                            armed_next      = 1'b1;
                        end
                    end
                    else if (gate_b_level == LEVEL_BLOCKED)
                    begin
                        // Second gate blocked: disarm and produce the measurement.
                        armed_next   = 1'b0;
                        elapsed_next = sat_elapsed(tick_count_reg);
                        if (tick_count_reg == '0)
                        begin
                            speed_next     = SPEED_MAX;
                            err_next       = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        else
                        begin
                            err_next   = 1'b0;
                            rem_next   = '0;
                            quot_next  = numerator_reg;
                            step_next  = '0;
                            state_next = ST_DIVIDE;
                        end
                    end
                end
            end

            ST_DIVIDE:
            begin
                if (rem_diff[COUNT_WIDTH])
                begin
                    rem_next  = rem_shift;
                    quot_next = {quot_reg[NUM_W-2:0], 1'b0};
                end
                else
                begin
                    rem_next  = rem_diff;
                    quot_next = {quot_reg[NUM_W-2:0], 1'b1};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    speed_next     = quot_next[SPEED_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The divider only ever runs with a nonzero divisor, disarmed, and with the
    // output register empty.
    `LGST_ASSERT_IMPL(a_div_nonzero, state_reg == ST_DIVIDE, tick_count_reg != '0)
    `LGST_ASSERT_IMPL(a_div_clean, state_reg == ST_DIVIDE, !armed_reg && !out_valid_reg)
    // The last divide step always delivers a result without the error flag.
    `LGST_ASSERT_NEXT(a_div_done,
        (state_reg == ST_DIVIDE) && (step_reg == STEP_LAST),
        out_valid_reg && !err_reg && (state_reg == ST_IDLE))
    // A zero-time result carries the maximum speed and an elapsed count of zero.
    `LGST_ASSERT_IMPL(a_zero_time, out_valid_reg && err_reg,
        (speed_reg == SPEED_MAX) && (elapsed_reg == '0))

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the light gate speed timer: directed table, then random runs.
module testbench;
    import lgst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // A gate level of this value means the beam is not interrupted.
    localparam logic BEAM_CLEAR = !LEVEL_BLOCKED;
    localparam int   PLAN_LEN   = 14;

    // One reading of the trap, as the block reports it on the result channel.
    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed;
        logic [SPEED_W-1:0]   speed;
        logic                 zero_err;
    } speed_reading_t;

    // One row of the directed table: an input item, how often it is sent, and
    // optionally the reading that it must produce, typed in by hand.
    typedef struct packed {
        logic           act;
        logic           gate_a;
        logic           gate_b;
        logic [31:0]    reps;
        logic           typed;
        speed_reading_t want;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 action = ACT_TICK;
    logic                 gate_a_level = BEAM_CLEAR;
    logic                 gate_b_level = BEAM_CLEAR;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [ELAPSED_W-1:0] elapsed_ticks;
    logic [SPEED_W-1:0]   speed_mm_s;
    logic                 zero_time_error;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [NUM_W-1:0]     distance_numerator = '0;

    // Our own copy of the timer state and of the distance register.
    logic                   timer_armed = 1'b0;
    logic [COUNT_WIDTH-1:0] tick_total = '0;
    logic [NUM_W-1:0]       numerator_now = NUM_RESET;

    // Readings that are owed by the block, oldest first.
    speed_reading_t pending_readings [$];

    int unsigned fail_count = 0;
    int unsigned effective_items = 0;
    int unsigned readings_issued = 0;
    bit          in_gaps_on = 1'b1;
    bit          out_gaps_on = 1'b1;

    plan_row_t plan [0:PLAN_LEN-1];

    light_gate_speed_timer u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .gate_a_level       (gate_a_level),
        .gate_b_level       (gate_b_level),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .elapsed_ticks      (elapsed_ticks),
        .speed_mm_s         (speed_mm_s),
        .zero_time_error    (zero_time_error),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .distance_numerator (distance_numerator)
    );

    // 2 ns clock period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The result side stalls at random while out_gaps_on is set.
    always @(posedge clk)
    begin
        out_stall <= out_gaps_on && ($urandom_range(99) < 18);
    end

    // Every failed comparison goes through here: one line, one count.
    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    // Moves the timer state on by one accepted item. A tick while armed counts
    // up to the counter maximum and then stays; an event while idle arms only
    // when the first gate is blocked, and then clears the count; an event while
    // armed stops the timer only when the second gate is blocked. A stop with a
    // zero count cannot divide, so it reports the top speed and raises the error.
    task automatic advance_timer(input logic act, input logic gate_a, input logic gate_b,
                                 output bit fired, output speed_reading_t reading,
                                 output bit moved);
        fired   = 1'b0;
        moved   = 1'b0;
        reading = '0;
        if (act == ACT_TICK)
        begin
            if (timer_armed && tick_total != COUNT_MAX)
            begin
                tick_total++;
                moved = 1'b1;
            end
        end
        else if (!timer_armed)
        begin
            if (gate_a == LEVEL_BLOCKED)
            begin
                tick_total  = '0;
                timer_armed = 1'b1;
                moved       = 1'b1;
            end
        end
        else if (gate_b == LEVEL_BLOCKED)
        begin
            timer_armed = 1'b0;
            moved       = 1'b1;
            fired       = 1'b1;
            // The elapsed field cannot show more than its own maximum.
            reading.elapsed = (tick_total > ELAPSED_MAX) ? ELAPSED_MAX
                                                         : ELAPSED_W'(tick_total);
            if (tick_total == '0)
            begin
                reading.speed    = SPEED_MAX;
                reading.zero_err = 1'b1;
            end
            else
            begin
                reading.speed    = SPEED_W'(numerator_now / tick_total);
                reading.zero_err = 1'b0;
            end
        end
    endtask

    // Offers one item, holds it steady through any stall, and on acceptance
    // books the reading that it will cause. The stall is looked at on the
    // falling edge, where it is settled, and the item is taken at the rising
    // edge that follows. A hand-typed reading replaces the predicted one.
    task automatic send_item(input logic act, input logic gate_a, input logic gate_b,
                             input bit use_typed, input speed_reading_t typed);
        bit             taken;
        bit             fired;
        bit             moved;
        speed_reading_t reading;
        while (in_gaps_on && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        gate_a_level <= gate_a;
        gate_b_level <= gate_b;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        advance_timer(act, gate_a, gate_b, fired, reading, moved);
        if (moved)
            effective_items++;
        if (fired)
        begin
            pending_readings.push_back(use_typed ? typed : reading);
            readings_issued++;
        end
    endtask

    // Writes the distance register; only called while nothing is in flight.
    task automatic write_numerator(input logic [NUM_W-1:0] value);
        bit taken;
        cfg_valid          <= 1'b1;
        distance_numerator <= value;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        cfg_valid     <= 1'b0;
        numerator_now = value;
    endtask

    // Stops offering items, waits for every owed reading, then lets the
    // divider's worth of cycles go by so that nothing is left running.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    // Random traffic. Most of it is whole passes: an arming event, a run of
    // ticks with the odd harmless event mixed in, and a stopping event. The
    // rest is loose items of any kind. Run lengths are mostly short so that
    // readings come often, with a few long runs to reach large counts.
    task automatic run_phase(input int unsigned item_goal, input int unsigned reading_goal);
        int unsigned first_items;
        int unsigned first_readings;
        int unsigned span;
        int unsigned pick;
        first_items    = effective_items;
        first_readings = readings_issued;
        while (effective_items - first_items < item_goal ||
               readings_issued - first_readings < reading_goal)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
            begin
                send_item(ACT_EVENT, LEVEL_BLOCKED, 1'($urandom), 1'b0, '0);
                pick = $urandom_range(99);
                if (pick < 15)
                    span = 0;
                else if (pick < 95)
                    span = $urandom_range(24, 1);
                else
                    span = $urandom_range(300, 25);
                repeat (span)
                begin
                    if ($urandom_range(99) < 8)
                        send_item(ACT_EVENT, 1'($urandom), BEAM_CLEAR, 1'b0, '0);
                    send_item(ACT_TICK, 1'($urandom), 1'($urandom), 1'b0, '0);
                end
                send_item(ACT_EVENT, 1'($urandom), LEVEL_BLOCKED, 1'b0, '0);
            end
            else
            begin
                send_item(1'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
            end
        end
    endtask

    // Result checker. The handshake is judged on the falling edge, where the
    // outputs and our own stall are settled; the result is taken at the next
    // rising edge. Every field is compared with the oldest owed reading.
    always @(negedge clk)
    begin : check_results
        speed_reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                report_mismatch($sformatf("reading %0d/%0d/%0d with none owed",
                                          elapsed_ticks, speed_mm_s, zero_time_error));
            end
            else
            begin
                want = pending_readings.pop_front();
                if (elapsed_ticks !== want.elapsed)
                    report_mismatch($sformatf("elapsed_ticks %0d, wanted %0d",
                                              elapsed_ticks, want.elapsed));
                if (speed_mm_s !== want.speed)
                    report_mismatch($sformatf("speed_mm_s %0d, wanted %0d",
                                              speed_mm_s, want.speed));
                if (zero_time_error !== want.zero_err)
                    report_mismatch($sformatf("zero_time_error %0d, wanted %0d",
                                              zero_time_error, want.zero_err));
            end
        end
    end

    // Main sequence: reset, the directed table at the reset distance, then
    // random phases at the distance extremes, at one and at a random value.
    initial
    begin : stimulus
        logic [NUM_W-1:0] phase_numerator [0:3];

        // The directed table. Readings are typed in only where they follow at
        // a glance from the reset distance of 45720.
        plan = '{
            // A tick while idle does nothing.
            '{ACT_TICK,  LEVEL_BLOCKED, LEVEL_BLOCKED, 32'd1, 1'b0, '0},
            // Idle events that do not block the first gate do nothing.
            '{ACT_EVENT, BEAM_CLEAR,    LEVEL_BLOCKED, 32'd1, 1'b0, '0},
            '{ACT_EVENT, BEAM_CLEAR,    BEAM_CLEAR,    32'd1, 1'b0, '0},
            // Both gates blocked while idle: the timer only arms.
            '{ACT_EVENT, LEVEL_BLOCKED, LEVEL_BLOCKED, 32'd1, 1'b0, '0},
            // Stop with no ticks counted: top speed and the error flag.
            '{ACT_EVENT, LEVEL_BLOCKED, LEVEL_BLOCKED, 32'd1, 1'b1,
              '{16'd0, SPEED_MAX, 1'b1}},
            '{ACT_EVENT, LEVEL_BLOCKED, BEAM_CLEAR,    32'd1, 1'b0, '0},
            '{ACT_TICK,  BEAM_CLEAR,    BEAM_CLEAR,    32'd1, 1'b0, '0},
            // First gate blocked again while armed: the count carries on.
            '{ACT_EVENT, LEVEL_BLOCKED, BEAM_CLEAR,    32'd1, 1'b0, '0},
            // Neither relevant gate blocked: nothing happens.
            '{ACT_EVENT, BEAM_CLEAR,    BEAM_CLEAR,    32'd1, 1'b0, '0},
            '{ACT_TICK,  LEVEL_BLOCKED, BEAM_CLEAR,    32'd2, 1'b0, '0},
            '{ACT_EVENT, BEAM_CLEAR,    LEVEL_BLOCKED, 32'd1, 1'b1,
              '{16'd3, 16'd15240, 1'b0}},
            '{ACT_EVENT, LEVEL_BLOCKED, BEAM_CLEAR,    32'd1, 1'b0, '0},
            '{ACT_TICK,  BEAM_CLEAR,    LEVEL_BLOCKED, 32'd1, 1'b0, '0},
            '{ACT_EVENT, BEAM_CLEAR,    LEVEL_BLOCKED, 32'd1, 1'b1,
              '{16'd1, NUM_RESET, 1'b0}}
        };
        phase_numerator[0] = '1;
        phase_numerator[1] = '0;
        phase_numerator[2] = NUM_W'(1);
        phase_numerator[3] = NUM_W'($urandom);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_LEN; r++)
            repeat (plan[r].reps)
                send_item(plan[r].act, plan[r].gate_a, plan[r].gate_b,
                          plan[r].typed, plan[r].want);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            // The third phase runs flat out on both sides, with no idling.
            in_gaps_on  = (p != 2);
            out_gaps_on = (p != 2);
            write_numerator(phase_numerator[p]);
            run_phase(130, 4);
            wait_drained();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: the slowest legal run is far shorter than this.
    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
